// ----- design/jhgs_pkg.sv -----
`timescale 1ns / 1ps
package jhgs_pkg;

   // Default grid edge length
   localparam int GRID_MAX_DEF = 128;

   // Value width (unsigned Q5.26, at most 30.0)
   localparam int VAL_W = 31;

   // Fixed temperatures in Q5.26
   localparam logic [VAL_W-1:0] Q_ONE    = 31'd67108864;
   localparam logic [VAL_W-1:0] Q_TEN    = 31'd671088640;
   localparam logic [VAL_W-1:0] Q_TWENTY = 31'd1342177280;

   // Edge ramp span (10.0) as a dividend
   localparam int SPAN_W = 30;
   localparam logic [SPAN_W-1:0] SPAN = 30'd671088640;

   // Control register indexes
   localparam logic [1:0] CSR_GRID_SIZE = 2'd0;
   localparam logic [1:0] CSR_MAX_ITER  = 2'd1;
   localparam logic [1:0] CSR_EPS       = 2'd2;
   localparam logic [1:0] CSR_CHECK     = 2'd3;

   // Request modes
   localparam logic MODE_RUN  = 1'b0;
   localparam logic MODE_READ = 1'b1;

endpackage

// ----- design/jacobi_heat_grid_solver.sv -----
`timescale 1ns / 1ps
// Jacobi heat solver on a square grid with a 5-point stencil.
// Request channel: start with req_mode/req_row/req_col, taken when busy is low.
// Mode run builds the start grid in two buffers and sweeps until the largest
// cell change, measured every check_interval sweeps, is at or below the limit,
// or max_iterations sweeps are done. Mode read returns one cell of the newest
// buffer; cells outside the last run's grid read as zero.
// Response: rsp_valid strobes for one cycle with the cell value, the sweep count
// and the last measured error. The receiver cannot stall; each response is
// taken in its cycle.
// A read answers once its cell has passed the registered memory read and the
// response register. A run of side n clears the grid, divides the ramp step,
// writes the edges, then sweeps (four neighbor reads on one memory port per cell
// and one stop test per sweep) with an error scan at each check. busy stays high
// for the whole item.
// Control registers are written through csr_*, always ready; write them only
// while the block is idle.
// Reset: registers return to their defaults, no grid is held, reads give zero.
// The grid memories need no clearing pass; a run writes every cell it uses.
module jacobi_heat_grid_solver #(
   parameter int MAX_GRID = jhgs_pkg::GRID_MAX_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  logic                      req_mode,
   input  logic [6:0]                req_row,
   input  logic [6:0]                req_col,
   output logic                      rsp_valid,
   output logic [jhgs_pkg::VAL_W-1:0] rsp_cell_value,
   output logic [19:0]               rsp_iterations_done,
   output logic [jhgs_pkg::VAL_W-1:0] rsp_final_error,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [1:0]                csr_index,
   input  logic [31:0]               csr_wdata
);
   import jhgs_pkg::*;

   localparam int CW    = (MAX_GRID > 1) ? $clog2(MAX_GRID) : 1;
   localparam int DEPTH = MAX_GRID * MAX_GRID;
   localparam int AW    = $clog2(DEPTH);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_CLEAR = 3'd1;
   localparam logic [2:0] ST_DIV   = 3'd2;
   localparam logic [2:0] ST_EDGE  = 3'd3;
   localparam logic [2:0] ST_LOOP  = 3'd4;
   localparam logic [2:0] ST_SWEEP = 3'd5;
   localparam logic [2:0] ST_ERR   = 3'd6;
   localparam logic [2:0] ST_READ  = 3'd7;

   function automatic logic [AW-1:0] cell_addr(input logic [CW-1:0] r,
                                                input logic [CW-1:0] c);
      return AW'(r) * AW'(MAX_GRID) + AW'(c);
   endfunction

   // Grid memories
   logic [VAL_W-1:0] grid_a_mem [DEPTH];
   logic [VAL_W-1:0] grid_b_mem [DEPTH];

   logic [2:0]        state_ff, state_in;
   logic [CW-1:0]     row_ff, row_in, col_ff, col_in, last_ff, last_in;
   logic [2:0]        phase_ff, phase_in;
   logic [32:0]       acc_ff, acc_in;
   logic              ran_ff, ran_in, cur_a_ff, cur_a_in, in_range_ff, in_range_in;
   logic [19:0]       sweep_ff, sweep_in, since_ff, since_in;
   logic [VAL_W-1:0]  err_ff, err_in, emax_ff, emax_in;
   logic [SPAN_W-1:0] dvd_ff, dvd_in, quo_ff, quo_in, qstep_ff, qstep_in, q_ff, q_in;
   logic [CW-1:0]     rem_ff, rem_in, rstep_ff, rstep_in, r_ff, r_in;
   logic [4:0]        dcnt_ff, dcnt_in;
   logic [7:0]        gs_ff;
   logic [19:0]       maxit_ff, ci_ff;
   logic [26:0]       eps_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [VAL_W-1:0]  rsp_cell_ff, rsp_cell_in;
   logic [VAL_W-1:0]  rda_ff, rdb_ff;

   logic              we;
   logic              we_a, we_b;
   logic [AW-1:0]     wr_addr, rd_addr;
   logic [VAL_W-1:0]  wr_data;

   logic              take;
   logic [31:0]       n_wide;
   logic [CW-1:0]     lastm1;
   logic [19:0]       ci_eff, since1;
   logic [VAL_W-1:0]  src, diff, dmax;
   logic [32:0]       sum;
   logic [CW:0]       trial, rsum;
   logic              ge;

   assign busy                = (state_ff != ST_IDLE);
   assign take                = start && !busy;
   assign csr_ready           = 1'b1;
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_cell_value      = rsp_cell_ff;
   assign rsp_iterations_done = sweep_ff;
   assign rsp_final_error     = err_ff;

   // Shared datapath terms
   always_comb begin
      if (gs_ff < 8'd3) begin
         n_wide = 32'd3;
      end else if (32'(gs_ff) > 32'(MAX_GRID)) begin
         n_wide = 32'(MAX_GRID);
      end else begin
         n_wide = 32'(gs_ff);
      end
      lastm1 = last_ff - 1'b1;
      ci_eff = (ci_ff == 20'd0) ? 20'd1 : ci_ff;
      since1 = since_ff + 20'd1;
      src    = cur_a_ff ? rda_ff : rdb_ff;
      sum    = acc_ff + 33'(src);
      diff   = (rda_ff > rdb_ff) ? (rda_ff - rdb_ff) : (rdb_ff - rda_ff);
      dmax   = (diff > emax_ff) ? diff : emax_ff;
      trial  = {rem_ff, dvd_ff[SPAN_W-1]};
      ge     = (trial >= {1'b0, last_ff});
      rsum   = {1'b0, r_ff} + {1'b0, rstep_ff};
   end

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      last_in      = last_ff;
      phase_in     = phase_ff;
      acc_in       = acc_ff;
      ran_in       = ran_ff;
      cur_a_in     = cur_a_ff;
      in_range_in  = in_range_ff;
      sweep_in     = sweep_ff;
      since_in     = since_ff;
      err_in       = err_ff;
      emax_in      = emax_ff;
      dvd_in       = dvd_ff;
      quo_in       = quo_ff;
      rem_in       = rem_ff;
      dcnt_in      = dcnt_ff;
      qstep_in     = qstep_ff;
      rstep_in     = rstep_ff;
      q_in         = q_ff;
      r_in         = r_ff;
      rsp_valid_in = 1'b0;
      rsp_cell_in  = rsp_cell_ff;
      we           = 1'b0;
      we_a         = 1'b0;
      we_b         = 1'b0;
      wr_addr      = cell_addr(row_ff, col_ff);
      wr_data      = '0;
      rd_addr      = cell_addr(row_ff, col_ff);
      case (state_ff)
         ST_IDLE: begin
            rd_addr = cell_addr(CW'(req_row), CW'(req_col));
            if (take) begin
               if (req_mode == MODE_RUN) begin
                  last_in  = CW'(n_wide - 32'd1);
                  ran_in   = 1'b1;
                  sweep_in = '0;
                  since_in = '0;
                  err_in   = Q_ONE;
                  cur_a_in = 1'b1;
                  row_in   = '0;
                  col_in   = '0;
                  state_in = ST_CLEAR;
               end else begin
                  in_range_in = ran_ff && (32'(req_row) <= 32'(last_ff))
                                && (32'(req_col) <= 32'(last_ff));
                  state_in    = ST_READ;
               end
            end
         end
         ST_READ: begin
            rsp_valid_in = 1'b1;
            rsp_cell_in  = in_range_ff ? src : '0;
            state_in     = ST_IDLE;
         end
         ST_CLEAR: begin
            // zero every cell of the run grid in both buffers
            we = 1'b1;
            if (col_ff == last_ff) begin
               col_in = '0;
               if (row_ff == last_ff) begin
                  dvd_in   = SPAN;
                  quo_in   = '0;
                  rem_in   = '0;
                  dcnt_in  = '0;
                  state_in = ST_DIV;
               end else begin
                  row_in = row_ff + 1'b1;
               end
            end else begin
               col_in = col_ff + 1'b1;
            end
         end
         ST_DIV: begin
            // one quotient bit of span / (n-1) per cycle
            rem_in  = ge ? CW'(trial - {1'b0, last_ff}) : CW'(trial);
            dvd_in  = dvd_ff << 1;
            quo_in  = {quo_ff[SPAN_W-2:0], ge};
            dcnt_in = dcnt_ff + 5'd1;
            if (dcnt_ff == 5'(SPAN_W - 1)) begin
               qstep_in = {quo_ff[SPAN_W-2:0], ge};
               rstep_in = rem_in;
               q_in     = '0;
               r_in     = '0;
               col_in   = '0;
               phase_in = '0;
               state_in = ST_EDGE;
            end
         end
         ST_EDGE: begin
            // top, left, right and bottom edge cells in turn for each ramp position
            we = 1'b1;
            case (phase_ff)
               3'd0: begin
                  wr_addr = cell_addr('0, col_ff);
                  wr_data = Q_TEN + VAL_W'(q_ff);
               end
               3'd1: begin
                  wr_addr = cell_addr(col_ff, '0);
                  wr_data = Q_TEN + VAL_W'(q_ff);
               end
               3'd2: begin
                  wr_addr = cell_addr(col_ff, last_ff);
                  wr_data = Q_TWENTY + VAL_W'(q_ff);
               end
               default: begin
                  wr_addr = cell_addr(last_ff, col_ff);
                  wr_data = Q_TWENTY + VAL_W'(q_ff);
               end
            endcase
            if (phase_ff == 3'd3) begin
               phase_in = '0;
               if (col_ff == last_ff) begin
                  state_in = ST_LOOP;
               end else begin
                  col_in = col_ff + 1'b1;
                  if (rsum >= {1'b0, last_ff}) begin
                     r_in = CW'(rsum - {1'b0, last_ff});
                     q_in = q_ff + qstep_ff + 1'b1;
                  end else begin
                     r_in = CW'(rsum);
                     q_in = q_ff + qstep_ff;
                  end
               end
            end else begin
               phase_in = phase_ff + 3'd1;
            end
         end
         ST_LOOP: begin
            if ((sweep_ff < maxit_ff) && (err_ff > VAL_W'(eps_ff))) begin
               row_in   = CW'(1);
               col_in   = CW'(1);
               phase_in = '0;
               state_in = ST_SWEEP;
            end else begin
               rsp_valid_in = 1'b1;
               rsp_cell_in  = '0;
               state_in     = ST_IDLE;
            end
         end
         ST_SWEEP: begin
            // read four neighbors, then write their mean
            case (phase_ff)
               3'd0: rd_addr = cell_addr(row_ff, col_ff + 1'b1);
               3'd1: rd_addr = cell_addr(row_ff, col_ff - 1'b1);
               3'd2: rd_addr = cell_addr(row_ff - 1'b1, col_ff);
               3'd3: rd_addr = cell_addr(row_ff + 1'b1, col_ff);
               default: rd_addr = cell_addr(row_ff, col_ff);
            endcase
            phase_in = phase_ff + 3'd1;
            case (phase_ff)
               3'd0: acc_in = acc_ff;
               3'd1: acc_in = 33'(src);
               default: acc_in = sum;
            endcase
            if (phase_ff == 3'd4) begin
               we_a     = !cur_a_ff;
               we_b     = cur_a_ff;
               wr_data  = sum[32:2];
               phase_in = '0;
               if (col_ff == lastm1) begin
                  col_in = CW'(1);
                  if (row_ff == lastm1) begin
                     cur_a_in = !cur_a_ff;
                     sweep_in = sweep_ff + 20'd1;
                     if (since1 == ci_eff) begin
                        since_in = '0;
                        row_in   = '0;
                        col_in   = '0;
                        emax_in  = '0;
                        state_in = ST_ERR;
                     end else begin
                        since_in = since1;
                        state_in = ST_LOOP;
                     end
                  end else begin
                     row_in = row_ff + 1'b1;
                  end
               end else begin
                  col_in = col_ff + 1'b1;
               end
            end
         end
         ST_ERR: begin
            // largest difference between the buffers, a read phase then a compare phase per cell
            if (phase_ff == 3'd0) begin
               phase_in = 3'd1;
            end else begin
               phase_in = '0;
               emax_in  = dmax;
               if (col_ff == last_ff) begin
                  col_in = '0;
                  if (row_ff == last_ff) begin
                     err_in   = dmax;
                     state_in = ST_LOOP;
                  end else begin
                     row_in = row_ff + 1'b1;
                  end
               end else begin
                  col_in = col_ff + 1'b1;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         phase_ff     <= '0;
         ran_ff       <= 1'b0;
         cur_a_ff     <= 1'b1;
         sweep_ff     <= '0;
         since_ff     <= '0;
         err_ff       <= Q_ONE;
         last_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         gs_ff        <= 8'd128;
         maxit_ff     <= 20'd1000000;
         eps_ff       <= 27'd67;
         ci_ff        <= 20'd10000;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         ran_ff       <= ran_in;
         cur_a_ff     <= cur_a_in;
         sweep_ff     <= sweep_in;
         since_ff     <= since_in;
         err_ff       <= err_in;
         last_ff      <= last_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_GRID_SIZE: gs_ff    <= csr_wdata[7:0];
               CSR_MAX_ITER:  maxit_ff <= csr_wdata[19:0];
               CSR_EPS:       eps_ff   <= csr_wdata[26:0];
               CSR_CHECK:     ci_ff    <= csr_wdata[19:0];
               default:       gs_ff    <= gs_ff;
            endcase
         end
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      row_ff      <= row_in;
      col_ff      <= col_in;
      acc_ff      <= acc_in;
      in_range_ff <= in_range_in;
      emax_ff     <= emax_in;
      dvd_ff      <= dvd_in;
      quo_ff      <= quo_in;
      rem_ff      <= rem_in;
      dcnt_ff     <= dcnt_in;
      qstep_ff    <= qstep_in;
      rstep_ff    <= rstep_in;
      q_ff        <= q_in;
      r_ff        <= r_in;
      rsp_cell_ff <= rsp_cell_in;
   end

   // Grid memories: one write and one registered read each
   always_ff @(posedge clock) begin
      if (we || we_a) begin
         grid_a_mem[wr_addr] <= wr_data;
      end
      rda_ff <= grid_a_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (we || we_b) begin
         grid_b_mem[wr_addr] <= wr_data;
      end
      rdb_ff <= grid_b_mem[rd_addr];
   end

endmodule

// ----- test/jacobi_heat_grid_checker.sv -----
`timescale 1ns / 1ps
module jacobi_heat_grid_checker (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic                        busy,
   input  logic                        req_mode,
   input  logic [6:0]                  req_row,
   input  logic [6:0]                  req_col,
   input  logic                        rsp_valid,
   input  logic [jhgs_pkg::VAL_W-1:0]  rsp_cell_value,
   input  logic [19:0]                 rsp_iterations_done,
   input  logic [jhgs_pkg::VAL_W-1:0]  rsp_final_error,
   input  logic                        csr_valid,
   input  logic                        csr_ready,
   input  logic [1:0]                  csr_index,
   input  logic [31:0]                 csr_wdata,
   output int                          fail_count,
   output int                          outstanding
);
   import jhgs_pkg::*;

   localparam int SIDE  = GRID_MAX_DEF;
   localparam int CELLS = SIDE * SIDE;

   typedef struct packed {
      logic [VAL_W-1:0] cell_q;
      logic [19:0]      sweeps;
      logic [VAL_W-1:0] err;
   } heat_reply_t;

   heat_reply_t expected_replies[$];

   // Model copy of both grid buffers and the solver status
   logic [VAL_W-1:0] plane_a[CELLS];
   logic [VAL_W-1:0] plane_b[CELLS];
   int unsigned sweeps_done;
   int unsigned run_side;
   logic [VAL_W-1:0] err_meas;
   bit newest_a;

   // Model copy of the control registers
   int unsigned cfg_size;
   int unsigned cfg_max_iter;
   int unsigned cfg_eps;
   int unsigned cfg_check;

   function automatic logic [VAL_W-1:0] edge_ramp(int unsigned pos, logic [VAL_W-1:0] lo,
                                                  int unsigned n);
      longint unsigned step;
      step = (longint'(pos) * longint'(Q_TEN)) / longint'(n - 1);
      return lo + VAL_W'(step);
   endfunction

   // Build the boundary ramps and a zero interior in both buffers
   task automatic fill_start(int unsigned n);
      int unsigned last;
      logic [VAL_W-1:0] v;
      last = n - 1;
      for (int r = 0; r < n; r++)
         for (int c = 0; c < n; c++) begin
            plane_a[r*SIDE+c] = '0;
         end
      plane_a[0] = Q_TEN;
      plane_a[last] = Q_TWENTY;
      plane_a[last*SIDE] = Q_TWENTY;
      plane_a[last*SIDE+last] = Q_TWENTY + Q_TEN;
      for (int i = 1; i < last; i++) begin
         v = edge_ramp(i, Q_TEN, n);
         plane_a[i] = v;
         plane_a[i*SIDE] = v;
         v = edge_ramp(i, Q_TWENTY, n);
         plane_a[i*SIDE+last] = v;
         plane_a[last*SIDE+i] = v;
      end
      for (int r = 0; r < n; r++)
         for (int c = 0; c < n; c++) begin
            plane_b[r*SIDE+c] = plane_a[r*SIDE+c];
         end
   endtask

   // One Jacobi sweep from the newest buffer into the other
   task automatic relax(int unsigned n);
      logic [VAL_W+1:0] s;
      int k;
      for (int r = 1; r + 1 < n; r++)
         for (int c = 1; c + 1 < n; c++) begin
            k = r * SIDE + c;
            if (newest_a) begin
               s = plane_a[k+1] + plane_a[k-1] + plane_a[k-SIDE] + plane_a[k+SIDE];
               plane_b[k] = s[VAL_W+1:2];
            end else begin
               s = plane_b[k+1] + plane_b[k-1] + plane_b[k-SIDE] + plane_b[k+SIDE];
               plane_a[k] = s[VAL_W+1:2];
            end
         end
      newest_a = !newest_a;
   endtask

   function automatic logic [VAL_W-1:0] max_change(int unsigned n);
      logic [VAL_W-1:0] m, d;
      m = '0;
      for (int r = 0; r < n; r++)
         for (int c = 0; c < n; c++) begin
            d = (plane_a[r*SIDE+c] > plane_b[r*SIDE+c]) ?
                plane_a[r*SIDE+c] - plane_b[r*SIDE+c] : plane_b[r*SIDE+c] - plane_a[r*SIDE+c];
            if (d > m) m = d;
         end
      return m;
   endfunction

   task automatic solve_heat_run();
      int unsigned n, ci, since;
      n = cfg_size;
      ci = (cfg_check == 0) ? 1 : cfg_check;
      if (n < 3) n = 3;
      if (n > SIDE) n = SIDE;
      fill_start(n);
      run_side = n;
      sweeps_done = 0;
      err_meas = Q_ONE;
      newest_a = 1'b1;
      since = 0;
      while (sweeps_done < cfg_max_iter && err_meas > cfg_eps) begin
         relax(n);
         sweeps_done++;
         since++;
         if (since == ci) begin
            since = 0;
            err_meas = max_change(n);
         end
      end
   endtask

   function automatic heat_reply_t predict_reply(logic mode, int unsigned row, int unsigned col);
      heat_reply_t rep;
      rep.cell_q = '0;
      if (mode == MODE_READ && row < run_side && col < run_side)
         rep.cell_q = newest_a ? plane_a[row*SIDE+col] : plane_b[row*SIDE+col];
      rep.sweeps = sweeps_done[19:0];
      rep.err = err_meas;
      return rep;
   endfunction

   // Track registers, predict on each accepted word, check each response
   always @(posedge clock) begin
      heat_reply_t want;
      if (reset) begin
         expected_replies.delete();
         fail_count = 0;
         sweeps_done = 0;
         run_side = 0;
         err_meas = Q_ONE;
         newest_a = 1'b1;
         cfg_size = 128;
         cfg_max_iter = 1000000;
         cfg_eps = 67;
         cfg_check = 10000;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_GRID_SIZE: cfg_size = csr_wdata[7:0];
               CSR_MAX_ITER:  cfg_max_iter = csr_wdata[19:0];
               CSR_EPS:       cfg_eps = csr_wdata[26:0];
               CSR_CHECK:     cfg_check = csr_wdata[19:0];
               default:       ;
            endcase
         end
         if (rsp_valid) begin
            if (expected_replies.size() == 0) begin
               $error("response with nothing expected");
               fail_count++;
            end else begin
               want = expected_replies.pop_front();
               if (rsp_cell_value !== want.cell_q) begin
                  $error("cell_value: expected %0d, got %0d", want.cell_q, rsp_cell_value);
                  fail_count++;
               end
               if (rsp_iterations_done !== want.sweeps) begin
                  $error("iterations_done: expected %0d, got %0d", want.sweeps,
                         rsp_iterations_done);
                  fail_count++;
               end
               if (rsp_final_error !== want.err) begin
                  $error("final_error: expected %0d, got %0d", want.err, rsp_final_error);
                  fail_count++;
               end
            end
         end
         if (start && !busy) begin
            if (req_mode == MODE_RUN) solve_heat_run();
            expected_replies.push_back(predict_reply(req_mode, req_row, req_col));
         end
      end
      outstanding = expected_replies.size();
   end

endmodule

// ----- test/jacobi_heat_grid_solver_tb.sv -----
`timescale 1ns / 1ps
module jacobi_heat_grid_solver_tb;
   import jhgs_pkg::*;

   localparam int CYCLE_LIMIT = 6000000;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              start = 1'b0;
   logic              busy;
   logic              req_mode = MODE_READ;
   logic [6:0]        req_row = '0;
   logic [6:0]        req_col = '0;
   logic              rsp_valid;
   logic [VAL_W-1:0]  rsp_cell_value;
   logic [19:0]       rsp_iterations_done;
   logic [VAL_W-1:0]  rsp_final_error;
   logic              csr_valid = 1'b0;
   logic              csr_ready;
   logic [1:0]        csr_index = CSR_GRID_SIZE;
   logic [31:0]       csr_wdata = '0;

   int  fail_count;
   int  outstanding;
   int  cycles = 0;
   bit  gaps_on = 1'b1;
   int unsigned run_side = 3;

   jacobi_heat_grid_solver dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_mode(req_mode), .req_row(req_row), .req_col(req_col),
      .rsp_valid(rsp_valid), .rsp_cell_value(rsp_cell_value),
      .rsp_iterations_done(rsp_iterations_done), .rsp_final_error(rsp_final_error),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   jacobi_heat_grid_checker checker_i (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_mode(req_mode), .req_row(req_row), .req_col(req_col),
      .rsp_valid(rsp_valid), .rsp_cell_value(rsp_cell_value),
      .rsp_iterations_done(rsp_iterations_done), .rsp_final_error(rsp_final_error),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_wdata(csr_wdata), .fail_count(fail_count), .outstanding(outstanding)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Stop a hung run
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   // Send one word; hold start until the block takes it
   task automatic issue_request(logic mode, logic [6:0] row, logic [6:0] col);
      if (gaps_on && $urandom_range(99) < 36) begin
         @(negedge clock) start <= 1'b0;
         repeat ($urandom_range(3)) @(negedge clock);
      end
      @(negedge clock);
      start <= 1'b1;
      req_mode <= mode;
      req_row <= row;
      req_col <= col;
      while (busy) @(negedge clock);
      @(posedge clock);
   endtask

   task automatic write_csr(logic [1:0] idx, logic [31:0] data);
      if (gaps_on && $urandom_range(99) < 36) repeat ($urandom_range(1, 3)) @(negedge clock);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock) csr_valid <= 1'b0;
   endtask

   // Hold off until every response is in, then let the block settle
   task automatic wait_drained();
      @(negedge clock) start <= 1'b0;
      while (outstanding != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic set_solver(int unsigned size, int unsigned iters, int unsigned eps,
                             int unsigned check);
      wait_drained();
      write_csr(CSR_GRID_SIZE, size);
      write_csr(CSR_MAX_ITER, iters);
      write_csr(CSR_EPS, eps);
      write_csr(CSR_CHECK, check);
      run_side = (size < 3) ? 3 : (size > 128) ? 128 : size;
   endtask

   task automatic random_read();
      logic [6:0] r, c;
      if ($urandom_range(99) < 75) begin
         r = 7'($urandom_range(run_side - 1));
         c = 7'($urandom_range(run_side - 1));
      end else begin
         r = 7'($urandom);
         c = 7'($urandom);
      end
      issue_request(MODE_READ, r, c);
   endtask

   initial begin
      int unsigned size, iters, eps, check;
      repeat (4) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      // Reads before any run return zero
      issue_request(MODE_READ, 7'd0, 7'd0);
      issue_request(MODE_READ, 7'd127, 7'd127);

      // Undersized grid saturates to 3; zero sweep limit runs nothing
      set_solver(0, 0, 0, 1);
      issue_request(MODE_RUN, 7'd0, 7'd0);
      issue_request(MODE_READ, 7'd0, 7'd2);

      // Oversized grid saturates to the full grid; one sweep, one error scan
      set_solver(255, 1, 0, 1);
      issue_request(MODE_RUN, 7'd127, 7'd127);
      issue_request(MODE_READ, 7'd0, 7'd0);
      issue_request(MODE_READ, 7'd0, 7'd127);
      issue_request(MODE_READ, 7'd127, 7'd0);
      issue_request(MODE_READ, 7'd127, 7'd127);
      issue_request(MODE_READ, 7'd1, 7'd1);
      issue_request(MODE_READ, 7'd64, 7'd64);
      issue_request(MODE_READ, 7'd126, 7'd1);

      // Limit at 1.0 stops before the first sweep; zero check interval acts as one
      set_solver(5, 1000000, 67108864, 0);
      issue_request(MODE_RUN, 7'd0, 7'd0);
      issue_request(MODE_READ, 7'd4, 7'd4);
      issue_request(MODE_READ, 7'd5, 7'd0);

      // Smallest grid converges at once; interval never reached leaves error at 1.0
      set_solver(3, 1000000, 0, 0);
      issue_request(MODE_RUN, 7'd0, 7'd0);
      issue_request(MODE_READ, 7'd1, 7'd1);
      set_solver(4, 5, 0, 1000000);
      issue_request(MODE_RUN, 7'd0, 7'd0);
      issue_request(MODE_READ, 7'd2, 7'd1);
      // Register change after a run leaves the stored grid alone
      set_solver(9, 3, 5, 2);
      issue_request(MODE_READ, 7'd1, 7'd2);
      issue_request(MODE_READ, 7'd3, 7'd3);

      // Random phases: one run with random registers, then reads of its grid
      for (int ph = 0; ph < 20; ph++) begin
         gaps_on = !(ph >= 8 && ph < 12);
         size = (ph == 5) ? 128 : $urandom_range(0, 12);
         iters = (ph == 5) ? 1 : $urandom_range(0, 60);
         case ($urandom_range(3))
            0: eps = 0;
            1: eps = $urandom_range(0, 1 << 20);
            2: eps = $urandom_range(0, 67108864);
            default: eps = $urandom & 32'h7ffffff;
         endcase
         case ($urandom_range(3))
            0: check = $urandom_range(0, 6);
            1: check = $urandom & 32'hfffff;
            default: check = $urandom_range(1, 3);
         endcase
         set_solver(size, iters, eps, check);
         issue_request(MODE_RUN, 7'($urandom), 7'($urandom));
         repeat ($urandom_range(40, 50)) random_read();
      end

      wait_drained();
      repeat (10) @(negedge clock);
      if (fail_count == 0 && outstanding == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
